FILE: sv/tac_pkg.sv
// Shared types, constants and helpers for the threshold alarm block.
package tac_pkg;

  localparam int NUM_SLOTS    = 4;
  localparam int COUNT_WIDTH  = 8;
  localparam int MASK_W       = 4;
  localparam int ACTIVE_SLOTS = (NUM_SLOTS < MASK_W) ? NUM_SLOTS : MASK_W;
  localparam int NUM_HIGH     = 2;
  localparam int SAMPLE_W     = 16;
  localparam int HYST_W       = 15;
  localparam int CONFIRM_W    = 8;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int OUT_W        = 32;
  localparam int COUNT_MAX    = (1 << COUNT_WIDTH) - 1;

  // Slot positions in the limit array and the result masks.
  localparam int SLOT_HIGH_WARN = 0;
  localparam int SLOT_HIGH_CRIT = 1;
  localparam int SLOT_LOW_WARN  = 2;
  localparam int SLOT_LOW_CRIT  = 3;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIGH_WARN = 3'd0,
    CFG_HIGH_CRIT = 3'd1,
    CFG_LOW_WARN  = 3'd2,
    CFG_LOW_CRIT  = 3'd3,
    CFG_HYST_HIGH = 3'd4,
    CFG_HYST_LOW  = 3'd5,
    CFG_ENABLE    = 3'd6,
    CFG_CONFIRM   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [MASK_W-1:0][SAMPLE_W-1:0] limit;
    logic [HYST_W-1:0]               hyst_high;
    logic [HYST_W-1:0]               hyst_low;
    logic [MASK_W-1:0]               slot_enable;
    logic [CONFIRM_W-1:0]            confirm_count;
  } cfg_t;

  // Clamp the confirm count to what the hit counter can hold.
  function automatic count_t sat_need(input logic [CONFIRM_W-1:0] c);
    logic [31:0] cw;
    cw = 32'(c);
    if (cw > 32'(COUNT_MAX)) begin
      return '1;
    end
    return cw[COUNT_WIDTH-1:0];
  endfunction

endpackage

FILE: sv/tac_cfg.sv
// Configuration register bank of the threshold alarm.
module tac_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tac_pkg::CFG_DATA_W-1:0] cfg_data,
  output tac_pkg::cfg_t                  cfg
);
  import tac_pkg::*;

  localparam logic [SAMPLE_W-1:0] LIM_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] LIM_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.limit[SLOT_HIGH_WARN] <= LIM_MAX;
      cfg.limit[SLOT_HIGH_CRIT] <= LIM_MAX;
      cfg.limit[SLOT_LOW_WARN]  <= LIM_MIN;
      cfg.limit[SLOT_LOW_CRIT]  <= LIM_MIN;
      cfg.hyst_high             <= '0;
      cfg.hyst_low              <= '0;
      cfg.slot_enable           <= '0;
      cfg.confirm_count         <= CONFIRM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_HIGH_WARN: cfg.limit[SLOT_HIGH_WARN] <= cfg_data[SAMPLE_W-1:0];
        CFG_HIGH_CRIT: cfg.limit[SLOT_HIGH_CRIT] <= cfg_data[SAMPLE_W-1:0];
        CFG_LOW_WARN:  cfg.limit[SLOT_LOW_WARN]  <= cfg_data[SAMPLE_W-1:0];
        CFG_LOW_CRIT:  cfg.limit[SLOT_LOW_CRIT]  <= cfg_data[SAMPLE_W-1:0];
        CFG_HYST_HIGH: cfg.hyst_high             <= cfg_data[HYST_W-1:0];
        CFG_HYST_LOW:  cfg.hyst_low              <= cfg_data[HYST_W-1:0];
        CFG_ENABLE:    cfg.slot_enable           <= cfg_data[MASK_W-1:0];
        CFG_CONFIRM:   cfg.confirm_count         <= cfg_data[CONFIRM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/tac_slot.sv
// Next-state logic of one alarm slot: hit test, recovery test, count update.
module tac_slot (
  input  logic                          enable,
  input  logic                          is_high,
  input  logic [tac_pkg::SAMPLE_W-1:0]  limit,
  input  logic [tac_pkg::HYST_W-1:0]    hyst,
  input  tac_pkg::count_t               need,
  input  logic [tac_pkg::SAMPLE_W-1:0]  sample,
  input  tac_pkg::count_t               count,
  input  logic                          asserted,
  output tac_pkg::count_t               count_next,
  output logic                          asserted_next
);
  import tac_pkg::*;

  localparam int WIDE_W = SAMPLE_W + 2;

  logic signed [WIDE_W-1:0] s_w;
  logic signed [WIDE_W-1:0] lim_w;
  logic signed [WIDE_W-1:0] hyst_w;
  logic signed [WIDE_W-1:0] rec_point;
  logic                     hit;
  logic                     rec;
  count_t                   count_inc;

  always_comb begin
    s_w       = WIDE_W'($signed(sample));
    lim_w     = WIDE_W'($signed(limit));
    hyst_w    = $signed(WIDE_W'(hyst));
    rec_point = is_high ? (lim_w - hyst_w) : (lim_w + hyst_w);
    hit       = is_high ? (s_w >= lim_w) : (s_w <= lim_w);
    rec       = is_high ? (s_w < rec_point) : (s_w > rec_point);
    count_inc = (count < need) ? count + count_t'(1) : count;

    count_next    = count;
    asserted_next = asserted;
    if (!enable) begin
      count_next    = '0;
      asserted_next = 1'b0;
    end else if (hit) begin
      count_next    = count_inc;
      asserted_next = asserted | (count_inc >= need);
    end else if (!asserted) begin
      count_next    = '0;
    end else if (rec) begin
      count_next    = '0;
      asserted_next = 1'b0;
    end
  end

endmodule

FILE: sv/threshold_alarm_with_confirmation_unit.sv
// Top level of the temperature threshold alarm with confirmation and hysteresis.
// Accepted beats go through the input register, then the result register.
// Throughput: one sample per cycle without stalls; one combinational slot update.
// rst (synchronous) clears both pipeline stages, all hit counts and asserted
// flags, and loads the register bank with its reset limits and settings.
module threshold_alarm_with_confirmation_unit (
  input  logic                           clk,
  input  logic                           rst,
  // Input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [15:0]                    s_tdata,   // [15:0] sample
  // Result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [3:0] asserted_mask, [7:4] changed_mask, [8] no_critical,
  // [24:9] sample_echo, [31:25] zero
  output logic [31:0]                    m_tdata,
  // Configuration write port
  input  logic                           cfg_we,
  input  logic [tac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tac_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tac_pkg::*;

  cfg_t cfg;

  // Input stage
  logic                in_valid;
  logic [SAMPLE_W-1:0] in_sample;

  // Slot state
  logic [MASK_W-1:0][COUNT_WIDTH-1:0] hit_counter;
  logic [MASK_W-1:0][COUNT_WIDTH-1:0] hit_counter_next;
  logic [MASK_W-1:0]                  slot_asserted;
  logic [MASK_W-1:0]                  slot_asserted_next;

  // Result stage
  logic                out_valid;
  logic [MASK_W-1:0]   out_asserted;
  logic [MASK_W-1:0]   out_changed;
  logic                out_no_crit;
  logic [SAMPLE_W-1:0] out_sample;

  count_t need;
  logic   advance;
  logic   fire;

  tac_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign need = sat_need(cfg.confirm_count);

  // The result register moves when it is empty or its beat is taken; the input
  // register refills whenever its content moves on, so a beat can enter each cycle.
  assign advance  = !out_valid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  // One update unit per active slot; high slots come first, then low slots.
  for (genvar i = 0; i < MASK_W; i++) begin : g_slot
    if (i < ACTIVE_SLOTS) begin : g_active
      logic is_high;
      assign is_high = (i < NUM_HIGH);
      tac_slot u_slot (
        .enable        (cfg.slot_enable[i]),
        .is_high       (is_high),
        .limit         (cfg.limit[i]),
        .hyst          (is_high ? cfg.hyst_high : cfg.hyst_low),
        .need          (need),
        .sample        (in_sample),
        .count         (hit_counter[i]),
        .asserted      (slot_asserted[i]),
        .count_next    (hit_counter_next[i]),
        .asserted_next (slot_asserted_next[i])
      );
    end else begin : g_idle
      // Slot without a limit: stays idle.
      assign hit_counter_next[i]   = '0;
      assign slot_asserted_next[i] = 1'b0;
    end
  end

  // Control and slot state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      out_valid     <= 1'b0;
      hit_counter   <= '0;
      slot_asserted <= '0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
      if (fire) begin
        hit_counter   <= hit_counter_next;
        slot_asserted <= slot_asserted_next;
      end
    end
  end

  // Payload registers: capture on accept, hold while stalled
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sample <= s_tdata[SAMPLE_W-1:0];
    end
    if (fire) begin
      out_asserted <= slot_asserted_next;
      out_changed  <= slot_asserted_next ^ slot_asserted;
      out_no_crit  <= !(slot_asserted_next[SLOT_HIGH_CRIT] |
                        slot_asserted_next[SLOT_LOW_CRIT]);
      out_sample   <= in_sample;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_W - 2*MASK_W - 1 - SAMPLE_W){1'b0}},
                     out_sample, out_no_crit, out_changed, out_asserted};

  // The critical flag in the result agrees with the asserted mask it carries.
  a_no_crit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[8] == !(m_tdata[1] | m_tdata[3])))
    else $error("no_critical disagrees with asserted mask");

  // The changed mask is the difference between old and new slot flags.
  a_changed: assert property (@(posedge clk) disable iff (rst)
    fire |=> (out_changed == ($past(slot_asserted) ^ slot_asserted)))
    else $error("changed mask does not match slot flag transition");

  // Slot 0, if disabled when a sample went through, is never left asserted.
  a_disabled: assert property (@(posedge clk) disable iff (rst)
    (fire && !cfg.slot_enable[0]) |=> (!slot_asserted[0] && hit_counter[0] == '0))
    else $error("disabled slot kept state");

  // Slot state moves only when a sample passes through the update logic.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> ($stable(slot_asserted) && $stable(hit_counter)))
    else $error("slot state changed without a sample");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the temperature threshold alarm with confirmation unit.
module testbench;
  import tac_pkg::*;

  // Result beat layout on m_tdata, lowest field last in the declaration.
  typedef struct packed {
    logic [6:0]  pad;
    logic [15:0] echo;
    logic        no_crit;
    logic [3:0]  changed;
    logic [3:0]  asserted;
  } alarm_result_t;

  localparam int SLOT_HW = 0;
  localparam int SLOT_HC = 1;
  localparam int SLOT_LW = 2;
  localparam int SLOT_LC = 3;
  localparam int HOLD_OFF_CYCLES = 300;  // long output stall, well past the pipe depth
  localparam int SETTLE_CYCLES   = 4;    // pipeline latency plus margin

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [15:0]           s_tdata   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [31:0]           m_tdata;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Settings the stimulus wants next; loaded into the block by load_config.
  cfg_t plan_cfg;

  // Predictor state: register bank as written, per-slot hit counts and flags.
  cfg_t              alarm_cfg;
  count_t            hit_cnt [MASK_W];
  logic [MASK_W-1:0] slot_on;

  alarm_result_t expected_alarms[$];

  int errors        = 0;
  int n_sent        = 0;
  int n_checked     = 0;
  int n_settings    = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  always #5 clk = ~clk;

  threshold_alarm_with_confirmation_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register bank contents right after reset.
  function automatic cfg_t reset_alarm_cfg();
    cfg_t c;
    c.limit[SLOT_HW]  = 16'h7FFF;
    c.limit[SLOT_HC]  = 16'h7FFF;
    c.limit[SLOT_LW]  = 16'h8000;
    c.limit[SLOT_LC]  = 16'h8000;
    c.hyst_high       = '0;
    c.hyst_low        = '0;
    c.slot_enable     = '0;
    c.confirm_count   = 8'd1;
    return c;
  endfunction

  // Advance the slot state by one sample and return the result beat it causes.
  function automatic alarm_result_t predict_alarm(input logic [15:0] raw);
    alarm_result_t     r;
    int                s;
    int                lim;
    count_t            need;
    logic [MASK_W-1:0] was;
    logic              hit;
    logic              recover;
    s    = int'($signed(raw));
    need = (int'(alarm_cfg.confirm_count) > COUNT_MAX) ? '1 : count_t'(alarm_cfg.confirm_count);
    was  = slot_on;
    for (int i = 0; i < MASK_W; i++) begin
      if (!alarm_cfg.slot_enable[i]) begin
        // Disabled slot drops its count and its flag.
        hit_cnt[i] = '0;
        slot_on[i] = 1'b0;
      end else begin
        lim = int'($signed(alarm_cfg.limit[i]));
        if (i < NUM_HIGH) begin
          hit     = s >= lim;
          recover = s < lim - int'(alarm_cfg.hyst_high);
        end else begin
          hit     = s <= lim;
          recover = s > lim + int'(alarm_cfg.hyst_low);
        end
        if (hit) begin
          // Saturate at the confirm count; a count left above it holds.
          if (hit_cnt[i] < need) begin
            hit_cnt[i] = hit_cnt[i] + 1'b1;
          end
          if (hit_cnt[i] >= need) begin
            slot_on[i] = 1'b1;
          end
        end else if (!slot_on[i]) begin
          hit_cnt[i] = '0;
        end else if (recover) begin
          hit_cnt[i] = '0;
          slot_on[i] = 1'b0;
        end
        // Asserted and inside the hysteresis band: hold count and flag.
      end
    end
    r.pad      = '0;
    r.echo     = raw;
    r.no_crit  = !(slot_on[SLOT_HC] || slot_on[SLOT_LC]);
    r.changed  = slot_on ^ was;
    r.asserted = slot_on;
    return r;
  endfunction

  task automatic flag_mismatch(input string field, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endtask

  // Track register writes and accepted samples, check every result beat.
  // Everything is sampled at the rising edge, before this edge's drives land.
  always @(posedge clk) begin
    alarm_result_t got;
    alarm_result_t want;
    if (rst) begin
      alarm_cfg = reset_alarm_cfg();
      slot_on   = '0;
      for (int i = 0; i < MASK_W; i++) begin
        hit_cnt[i] = '0;
      end
      expected_alarms.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_HIGH_WARN: alarm_cfg.limit[SLOT_HW]  = cfg_data;
          CFG_HIGH_CRIT: alarm_cfg.limit[SLOT_HC]  = cfg_data;
          CFG_LOW_WARN:  alarm_cfg.limit[SLOT_LW]  = cfg_data;
          CFG_LOW_CRIT:  alarm_cfg.limit[SLOT_LC]  = cfg_data;
          CFG_HYST_HIGH: alarm_cfg.hyst_high       = cfg_data[HYST_W-1:0];
          CFG_HYST_LOW:  alarm_cfg.hyst_low        = cfg_data[HYST_W-1:0];
          CFG_ENABLE:    alarm_cfg.slot_enable     = cfg_data[MASK_W-1:0];
          CFG_CONFIRM:   alarm_cfg.confirm_count   = cfg_data[CONFIRM_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        expected_alarms.push_back(predict_alarm(s_tdata));
        n_sent++;
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_alarms.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, expected none, actual %h", $time, m_tdata);
        end else begin
          want = expected_alarms.pop_front();
          n_checked++;
          flag_mismatch("asserted_mask", 16'(want.asserted), 16'(got.asserted));
          flag_mismatch("changed_mask",  16'(want.changed),  16'(got.changed));
          flag_mismatch("no_critical",   16'(want.no_crit),  16'(got.no_crit));
          flag_mismatch("sample_echo",   want.echo,          got.echo);
          flag_mismatch("pad bits",      16'(want.pad),      16'(got.pad));
        end
      end
    end
  end

  // Drive the receiver's ready: random stalls, or a long hold-off on request.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_OFF_CYCLES - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one sample beat, with random gaps ahead of it; return at the edge
  // that accepted it. s_tready only moves at rising edges, so read it at the
  // falling edge.
  task automatic send_sample(input logic [15:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
  endtask

  // Stop offering and wait until every expected result beat has arrived.
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (expected_alarms.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register word for one index; unused upper bits carry noise.
  function automatic logic [15:0] reg_word(input cfg_idx_t idx);
    logic [15:0] junk;
    junk = 16'($urandom);
    case (idx)
      CFG_HIGH_WARN: return plan_cfg.limit[SLOT_HW];
      CFG_HIGH_CRIT: return plan_cfg.limit[SLOT_HC];
      CFG_LOW_WARN:  return plan_cfg.limit[SLOT_LW];
      CFG_LOW_CRIT:  return plan_cfg.limit[SLOT_LC];
      CFG_HYST_HIGH: return {junk[15], plan_cfg.hyst_high};
      CFG_HYST_LOW:  return {junk[15], plan_cfg.hyst_low};
      CFG_ENABLE:    return {junk[15:4], plan_cfg.slot_enable};
      CFG_CONFIRM:   return {junk[15:8], plan_cfg.confirm_count};
      default:       return '0;
    endcase
  endfunction

  // Drain, then write the whole register bank from plan_cfg, one per cycle.
  task automatic load_config();
    wait_for_results();
    for (int r = 0; r <= int'(CFG_CONFIRM); r++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_idx_t'(r);
      cfg_data  <= reg_word(cfg_idx_t'(r));
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  function automatic int clamp_q88(input int v);
    if (v > 32767) begin
      return 32767;
    end
    if (v < -32768) begin
      return -32768;
    end
    return v;
  endfunction

  // Limits clustered around a random point so that a walk touches several slots.
  task automatic randomize_plan();
    int c;
    int hw;
    int lw;
    c = int'($urandom_range(40000)) - 20000;
    if ($urandom_range(9) == 0) begin
      for (int i = 0; i < MASK_W; i++) begin
        plan_cfg.limit[i] = 16'($urandom);
      end
    end else begin
      hw = c + int'($urandom_range(1500));
      lw = c - int'($urandom_range(1500));
      plan_cfg.limit[SLOT_HW] = 16'(hw);
      plan_cfg.limit[SLOT_HC] = 16'(hw + int'($urandom_range(1500)));
      plan_cfg.limit[SLOT_LW] = 16'(lw);
      plan_cfg.limit[SLOT_LC] = 16'(lw - int'($urandom_range(1500)));
    end
    case ($urandom_range(3))
      0:       plan_cfg.hyst_high = '0;
      3:       plan_cfg.hyst_high = 15'($urandom);
      default: plan_cfg.hyst_high = 15'($urandom_range(1024));
    endcase
    case ($urandom_range(3))
      0:       plan_cfg.hyst_low = '0;
      3:       plan_cfg.hyst_low = 15'($urandom);
      default: plan_cfg.hyst_low = 15'($urandom_range(1024));
    endcase
    plan_cfg.slot_enable = $urandom_range(1) ? 4'hF : 4'($urandom);
    case ($urandom_range(9))
      0:       plan_cfg.confirm_count = 8'd0;
      1:       plan_cfg.confirm_count = 8'd255;
      2:       plan_cfg.confirm_count = 8'($urandom);
      default: plan_cfg.confirm_count = 8'($urandom_range(5, 1));
    endcase
  endtask

  // Samples at the range extremes with every slot disabled: nothing asserts.
  task automatic test_reset_defaults();
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0000);
  endtask

  task automatic set_nominal_limits();
    plan_cfg.limit[SLOT_HW] = 16'h1900;  // 25.0
    plan_cfg.limit[SLOT_HC] = 16'h2800;  // 40.0
    plan_cfg.limit[SLOT_LW] = 16'hF600;  // -10.0
    plan_cfg.limit[SLOT_LC] = 16'hEC00;  // -20.0
    plan_cfg.hyst_high      = 15'h0200;  // 2.0 below high limits
    plan_cfg.hyst_low       = 15'h0100;  // 1.0 above low limits
    plan_cfg.slot_enable    = 4'hF;
  endtask

  // Walk the confirm, hysteresis, disable and confirm-change behavior by hand.
  task automatic test_directed_sequences();
    set_nominal_limits();
    plan_cfg.confirm_count = 8'd3;
    load_config();
    // Two hits, a miss that clears the count, then three hits to assert.
    send_sample(16'h1900);
    send_sample(16'h1900);
    send_sample(16'h0000);
    repeat (3) send_sample(16'h1900);
    // Inside the band, exactly at the recovery point, then one LSB past it.
    send_sample(16'h1770);
    send_sample(16'h1700);
    send_sample(16'h16FF);
    // Low side: both low slots assert; critical recovers past its band edge.
    repeat (3) send_sample(16'hEC00);
    send_sample(16'hED00);
    send_sample(16'hED01);
    // Full-scale high asserts both high slots.
    repeat (3) send_sample(16'h7FFF);
    // Disable every slot while some are asserted: the flags drop and show as changed.
    plan_cfg.slot_enable = 4'h0;
    load_config();
    send_sample(16'h8000);
    // Confirm count zero at the extreme limits and the widest hysteresis.
    plan_cfg.limit[SLOT_HW] = 16'h7FFF;
    plan_cfg.limit[SLOT_HC] = 16'h7FFF;
    plan_cfg.limit[SLOT_LW] = 16'h8000;
    plan_cfg.limit[SLOT_LC] = 16'h8000;
    plan_cfg.hyst_high      = 15'h7FFF;
    plan_cfg.hyst_low       = 15'h7FFF;
    plan_cfg.slot_enable    = 4'hF;
    plan_cfg.confirm_count  = 8'd0;
    load_config();
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    // Lower the confirm count below a count already built up.
    set_nominal_limits();
    plan_cfg.confirm_count = 8'd5;
    load_config();
    repeat (3) send_sample(16'h1900);
    plan_cfg.confirm_count = 8'd2;
    load_config();
    send_sample(16'h1900);
    send_sample(16'h1800);
  endtask

  // Random settings; per setting a random walk around one slot's limit,
  // snapping now and then to the limit and the band edges, with some noise.
  task automatic test_random_traffic(input int settings, input int per_setting);
    int          focus;
    int          lim;
    int          hyst;
    int          span;
    int          cur;
    int          pick;
    logic [15:0] v;
    for (int sc = 0; sc < settings; sc++) begin
      randomize_plan();
      load_config();
      focus = $urandom_range(3);
      lim   = int'($signed(plan_cfg.limit[focus]));
      hyst  = (focus < NUM_HIGH) ? int'(plan_cfg.hyst_high) : int'(plan_cfg.hyst_low);
      case ($urandom_range(2))
        0:       span = 16;
        1:       span = hyst / 2 + 32;
        default: span = 1024;
      endcase
      cur = lim;
      for (int k = 0; k < per_setting; k++) begin
        pick = $urandom_range(99);
        if (pick < 10) begin
          v = 16'($urandom);
        end else begin
          if (pick < 25) begin
            case ($urandom_range(5))
              0: cur = lim;
              1: cur = lim + 1;
              2: cur = lim - 1;
              3: cur = lim - hyst;
              4: cur = lim + hyst;
              default: cur = (focus < NUM_HIGH) ? lim - hyst - 1 : lim + hyst + 1;
            endcase
          end else if (pick >= 50) begin
            cur = cur + int'($urandom_range(2 * span)) - span;
          end
          // Otherwise dwell on the current value to build up hit counts.
          cur = clamp_q88(cur);
          v   = 16'(cur);
        end
        send_sample(v);
      end
    end
  endtask

  // Hold the receiver off for a long stretch while the sender keeps offering,
  // so the block fills and stalls its input; then pause until all is out.
  task automatic test_backpressure();
    int saved_idle;
    randomize_plan();
    plan_cfg.confirm_count = 8'd1;
    load_config();
    saved_idle    = send_idle_pct;
    send_idle_pct = 0;
    hold_req++;
    for (int k = 0; k < 40; k++) begin
      send_sample(16'(int'(plan_cfg.limit[$urandom_range(3)]) + int'($urandom_range(64)) - 32));
    end
    send_idle_pct = saved_idle;
    wait_for_results();
    for (int k = 0; k < 20; k++) begin
      send_sample(16'($urandom));
    end
  endtask

  initial begin
    plan_cfg = reset_alarm_cfg();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Sender sparse-ish, receiver mostly stalled.
    send_idle_pct = 32;
    recv_idle_pct = 72;
    test_reset_defaults();
    test_directed_sequences();
    test_random_traffic(5, 60);

    // Swap: sender mostly idle, receiver mostly ready.
    send_idle_pct = 72;
    recv_idle_pct = 32;
    test_random_traffic(5, 60);
    test_backpressure();

    // Full rate both ways.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(6, 60);

    wait_for_results();
    $display("Run covered %0d samples over %0d register settings, %0d result beats checked",
             n_sent, n_settings, n_checked);
    $display("Included: confirm and hysteresis edges, slot disable, long output hold-off");
    if (errors == 0 && expected_alarms.size() == 0) begin
      $display("threshold_alarm_with_confirmation_unit verification clean");
    end else begin
      $display("threshold_alarm_with_confirmation_unit verification failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5_000_000;
    $display("threshold_alarm_with_confirmation_unit verification failed");
    $finish;
  end

endmodule

FILE: sim.f
sv/tac_pkg.sv
sv/tac_cfg.sv
sv/tac_slot.sv
sv/threshold_alarm_with_confirmation_unit.sv
tb/sv/testbench.sv
